>>> hdl/kdop_pkg.sv
// Shared constants, types and helper functions for the k-DOP fitting block.
package kdop_pkg;

    localparam int COORD_BITS  = 24;
    localparam int DIST_BITS   = COORD_BITS + 2;
    localparam int NUM_PROJ    = 13;
    localparam int PROJ_IDX_W  = $clog2(NUM_PROJ);
    localparam int PLANE_IDX_W = 5;

    // First projection of the diagonal group and of the edge group.
    localparam logic [PROJ_IDX_W-1:0] PROJ_DIAG_BASE = PROJ_IDX_W'(3);
    localparam logic [PROJ_IDX_W-1:0] PROJ_EDGE_BASE = PROJ_IDX_W'(7);
    localparam logic [PROJ_IDX_W-1:0] NUM_AXES       = PROJ_IDX_W'(3);

    typedef enum logic [1:0] {
        DOP_6  = 2'd0,
        DOP_14 = 2'd1,
        DOP_18 = 2'd2,
        DOP_26 = 2'd3
    } t_dop_mode;

    localparam t_dop_mode DOP_MODE_RESET = DOP_14;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIST_BITS-1:0]  t_dist;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   load_point;
        logic                   point_last;
        logic                   emit_load;
        logic [PLANE_IDX_W-1:0] emit_index;
        logic                   emit_last;
        logic [PLANE_IDX_W-1:0] half;
        t_dop_mode              mode;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic logic [PLANE_IDX_W-1:0] kdop_plane_count(input t_dop_mode mode);
        logic [PLANE_IDX_W-1:0] k;
        case (mode)
            DOP_6:   k = PLANE_IDX_W'(6);
            DOP_14:  k = PLANE_IDX_W'(14);
            DOP_18:  k = PLANE_IDX_W'(18);
            DOP_26:  k = PLANE_IDX_W'(26);
            default: k = PLANE_IDX_W'(6);
        endcase
        return k;
    endfunction

    // Maps a position within one half of the output to a projection number.
    function automatic logic [PROJ_IDX_W-1:0] kdop_sel(input t_dop_mode mode,
                                                       input logic [PROJ_IDX_W-1:0] j);
        logic [PROJ_IDX_W-1:0] s;
        if (j < NUM_AXES) begin
            s = j;
        end else begin
            case (mode)
                DOP_14:  s = PROJ_DIAG_BASE + (j - NUM_AXES);
                DOP_18:  s = PROJ_EDGE_BASE + (j - NUM_AXES);
                DOP_26:  s = j;
                default: s = '0;
            endcase
        end
        return s;
    endfunction

endpackage

>>> hdl/kdop_if.sv
// Stream interfaces for the point input and the plane output channels.
interface kdop_pt_if import kdop_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    t_coord point_z;
    logic   last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface kdop_pl_if import kdop_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [PLANE_IDX_W-1:0] plane_index;
    t_dist                  plane_distance;
    logic                   last_plane;

    modport source (output valid, plane_index, plane_distance, last_plane, input ready);
    modport sink   (input valid, plane_index, plane_distance, last_plane, output ready);
endinterface

>>> hdl/kdop_fit_from_points.sv
// Top level of the k-DOP fitting block: controller and datapath.
//
// Usage: points stream in on i_point (valid/ready, one item per point). Each
// accepted point updates the running minimum and maximum of all thirteen
// projections in the same cycle, so points are taken at one per cycle. The
// item flagged last_point closes the set. The block then drops i_point.ready
// and sends k plane items on o_plane (k = 6, 14, 18 or 26 from dop_mode),
// minima first and then maxima, the final one flagged last_plane. After the
// last point is accepted the controller enters its emit state and its plane
// counter loads the single output register; emission runs at one plane per
// cycle while the receiver takes them. When o_plane.ready is low the current
// plane item is held and the counter waits. dop_mode is written through
// i_cfg_we and i_cfg_wdata; the user must do so only while the block is idle,
// as the block itself does not enforce it. Synchronous reset (i_rst_n low)
// empties the output register, returns to accepting points, forgets any
// partial set and sets dop_mode to 1 (k = 14).
module kdop_fit_from_points import kdop_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    kdop_pt_if.sink    i_point,
    kdop_pl_if.source  o_plane
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       pt_ready;

    assign i_point.ready = pt_ready;

    // Sequencing and the mode register live in the controller.
    kdop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt_valid  (i_point.valid),
        .i_pt_last   (i_point.last_point),
        .o_pt_ready  (pt_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Projection arithmetic, extreme tracking and the output register.
    kdop_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .i_point_x (i_point.point_x),
        .i_point_y (i_point.point_y),
        .i_point_z (i_point.point_z),
        .o_status  (dp_status),
        .o_plane   (o_plane)
    );

endmodule

>>> hdl/kdop_datapath.sv
// Projection adders, running min/max registers and the output register.
module kdop_datapath import kdop_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_coord     i_point_x,
    input  t_coord     i_point_y,
    input  t_coord     i_point_z,
    output t_dp_status o_status,
    kdop_pl_if.source  o_plane
);

    t_dist r_min [NUM_PROJ];
    t_dist r_max [NUM_PROJ];
    logic  r_set_started;

    logic                   r_out_valid;
    logic [PLANE_IDX_W-1:0] r_out_index;
    t_dist                  r_out_dist;
    logic                   r_out_last;

    t_dist                 p [NUM_PROJ];
    t_dist                 x, y, z;
    logic [PLANE_IDX_W-1:0] n_j;
    logic [PROJ_IDX_W-1:0]  n_sel;
    logic                   n_is_min;
    t_dist                  n_dist;

    always_comb begin
        x = DIST_BITS'(i_point_x);
        y = DIST_BITS'(i_point_y);
        z = DIST_BITS'(i_point_z);
        p[0]  = x;
        p[1]  = y;
        p[2]  = z;
        p[3]  = x + y + z;
        p[4]  = x - y + z;
        p[5]  = x + y - z;
        p[6]  = x - y - z;
        p[7]  = x + y;
        p[8]  = x + z;
        p[9]  = y + z;
        p[10] = x - y;
        p[11] = x - z;
        p[12] = y - z;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            for (int i = 0; i < NUM_PROJ; i++) begin
                if (!r_set_started || p[i] < r_min[i]) begin
                    r_min[i] <= p[i];
                end
                if (!r_set_started || p[i] > r_max[i]) begin
                    r_max[i] <= p[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_started <= 1'b0;
        end else if (i_cmd.load_point) begin
            r_set_started <= !i_cmd.point_last;
        end
    end

    // Minima fill the lower half of the plane numbers, maxima the upper.
    always_comb begin
        n_is_min = i_cmd.emit_index < i_cmd.half;
        n_j      = n_is_min ? i_cmd.emit_index : i_cmd.emit_index - i_cmd.half;
        n_sel    = kdop_sel(i_cmd.mode, n_j[PROJ_IDX_W-1:0]);
        n_dist   = n_is_min ? r_min[n_sel] : r_max[n_sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_plane.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_index <= i_cmd.emit_index;
            r_out_dist  <= n_dist;
            r_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_status.out_free       = !r_out_valid || o_plane.ready;
    assign o_plane.valid           = r_out_valid;
    assign o_plane.plane_index     = r_out_index;
    assign o_plane.plane_distance  = r_out_dist;
    assign o_plane.last_plane      = r_out_last;

endmodule

>>> hdl/kdop_ctrl.sv
// Controller: mode register, accumulate/emit sequencing and plane counter.
module kdop_ctrl import kdop_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_pt_valid,
    input  logic       i_pt_last,
    output logic       o_pt_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_ACCUM,
        S_EMIT
    } t_state;

    t_state                 r_state;
    t_dop_mode              r_mode;
    logic [PLANE_IDX_W-1:0] r_idx;
    logic [PLANE_IDX_W-1:0] r_count;

    logic pt_acc;
    logic emit_last;

    assign o_pt_ready = (r_state == S_ACCUM);
    assign pt_acc     = i_pt_valid && o_pt_ready;
    assign emit_last  = (r_idx == r_count - PLANE_IDX_W'(1));

    always_comb begin
        o_cmd.load_point = pt_acc;
        o_cmd.point_last = i_pt_last;
        o_cmd.emit_load  = (r_state == S_EMIT) && i_status.out_free;
        o_cmd.emit_index = r_idx;
        o_cmd.emit_last  = emit_last;
        o_cmd.half       = r_count >> 1;
        o_cmd.mode       = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_mode  <= DOP_MODE_RESET;
            r_idx   <= '0;
            r_count <= kdop_plane_count(DOP_MODE_RESET);
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_dop_mode'(i_cfg_wdata);
            end
            case (r_state)
                S_ACCUM: begin
                    if (pt_acc && i_pt_last) begin
                        r_state <= S_EMIT;
                        r_idx   <= '0;
                        r_count <= kdop_plane_count(r_mode);
                    end
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        r_idx <= r_idx + PLANE_IDX_W'(1);
                        if (emit_last) begin
                            r_state <= S_ACCUM;
                        end
                    end
                end
                default: begin
                    r_state <= S_ACCUM;
                end
            endcase
        end
    end

    a_last_point_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pt_acc && i_pt_last) |=> (r_state == S_EMIT && r_idx == '0))
        else $error("last point did not start emission at plane zero");

    a_emit_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_load && emit_last) |=> (r_state == S_ACCUM))
        else $error("controller did not return to accumulate after final plane");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx < r_count))
        else $error("plane counter ran past the plane count");

endmodule

>>> dv/tb_kdop_fit_from_points.sv
// Self-checking testbench for the k-DOP fitting block: directed table, then random point sets.
`timescale 1ns / 1ps

module tb_kdop_fit_from_points;
    import kdop_pkg::*;

    localparam int CLK_PERIOD_NS   = 12;
    localparam int RESET_CYCLES    = 10;
    // Cycles waited after the final plane item, before a mode write, for the
    // block to settle.
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_SETTLE      = 8;
    localparam int LIMIT_CYCLES    = 600000;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 92;

    localparam t_coord CMAX = 24'sh7FFFFF;
    localparam t_coord CMIN = 24'sh800000;
    localparam t_coord CZERO = '0;

    // Sender idle and receiver stall odds, in percent, for each random phase.
    localparam int SEND_IDLE  [NUM_PHASES] = '{0, 64, 0, 25, 0};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 64, 25, 0};

    // One plane item as the block should send it.
    typedef struct packed {
        logic [PLANE_IDX_W-1:0] plane_index;
        t_dist                  plane_distance;
        logic                   last_plane;
    } t_plane_exp;

    // One row of the directed table. When pin_en is set, the plane pin_plane
    // of the set that this row closes must carry exactly pin_dist; that value
    // is typed in by hand and replaces the computed one.
    typedef struct packed {
        logic                   cfg_en;
        t_dop_mode              cfg_mode;
        t_coord                 x;
        t_coord                 y;
        t_coord                 z;
        logic                   last;
        logic                   pin_en;
        logic [PLANE_IDX_W-1:0] pin_plane;
        t_dist                  pin_dist;
    } t_dir_row;

    localparam int NUM_DIRECTED = 20;

    // The block starts in the 14-plane mode after reset, so the first rows run
    // there. Single-point sets at the coordinate extremes hit the widest sums.
    localparam t_dir_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{1'b0, DOP_14, CMAX, CMAX, CMAX, 1'b1, 1'b1, 5'd3, t_dist'(25165821)},
        '{1'b0, DOP_14, CMIN, CMIN, CMIN, 1'b1, 1'b1, 5'd3, t_dist'(-25165824)},
        '{1'b0, DOP_14, CMAX, CMIN, CMAX, 1'b1, 1'b1, 5'd4, t_dist'(25165822)},
        '{1'b0, DOP_14, CMIN, CMAX, CMIN, 1'b1, 1'b1, 5'd4, t_dist'(-25165823)},
        '{1'b0, DOP_14, CZERO, CZERO, CZERO, 1'b1, 1'b1, 5'd13, t_dist'(0)},
        // A four-point set with mixed signs.
        '{1'b0, DOP_14, t_coord'(1), t_coord'(2), t_coord'(3), 1'b0, 1'b0, 5'd0, '0},
        '{1'b0, DOP_14, t_coord'(-4), t_coord'(5), t_coord'(-6), 1'b0, 1'b0, 5'd0, '0},
        '{1'b0, DOP_14, t_coord'(7), t_coord'(-8), t_coord'(9), 1'b0, 1'b0, 5'd0, '0},
        '{1'b0, DOP_14, CZERO, CZERO, CZERO, 1'b1, 1'b0, 5'd0, '0},
        '{1'b0, DOP_14, t_coord'(-1), t_coord'(-1), t_coord'(-1), 1'b1, 1'b1, 5'd6, t_dist'(1)},
        // The mode changes in the middle of this set; only the value seen
        // when the last point arrives decides which planes come out.
        '{1'b0, DOP_14, t_coord'(100), t_coord'(-200), t_coord'(300), 1'b0, 1'b0, 5'd0, '0},
        '{1'b0, DOP_14, t_coord'(-50), t_coord'(60), t_coord'(70), 1'b0, 1'b0, 5'd0, '0},
        '{1'b1, DOP_26, CMAX, CMIN, CZERO, 1'b1, 1'b1, 5'd13, t_dist'(8388607)},
        '{1'b1, DOP_6, CMIN, CMAX, CZERO, 1'b1, 1'b1, 5'd0, t_dist'(-8388608)},
        '{1'b1, DOP_18, CMAX, CMAX, CMIN, 1'b1, 1'b1, 5'd3, t_dist'(16777214)},
        '{1'b0, DOP_18, CMIN, CMAX, CMAX, 1'b0, 1'b0, 5'd0, '0},
        '{1'b0, DOP_18, CMAX, CMIN, CMIN, 1'b1, 1'b0, 5'd0, '0},
        '{1'b1, DOP_26, CMIN, CMIN, CMIN, 1'b0, 1'b0, 5'd0, '0},
        '{1'b0, DOP_26, CMAX, CMAX, CMAX, 1'b1, 1'b1, 5'd16, t_dist'(25165821)},
        '{1'b1, DOP_14, 24'sh555555, 24'shAAAAAA, 24'sh5A5A5A, 1'b1, 1'b0, 5'd0, '0}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    kdop_pt_if pt_if ();
    kdop_pl_if pl_if ();

    kdop_fit_from_points DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_point     (pt_if),
        .o_plane     (pl_if)
    );

    // Shadow of the block: running extremes of all thirteen projections, the
    // open-set flag and the plane mode as last written.
    t_dist      proj_lo [NUM_PROJ];
    t_dist      proj_hi [NUM_PROJ];
    logic       set_open;
    t_dop_mode  mode_now;

    t_plane_exp expected_planes [$];
    t_plane_exp head_plane;
    int         mismatch_count;
    int         idle_pct;
    int         stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;
    end

    // The run must finish well inside this bound even with the heaviest
    // stalling; reaching it means the block stopped moving items.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int plane_total(input t_dop_mode mode);
        case (mode)
            DOP_6:   return 6;
            DOP_14:  return 14;
            DOP_18:  return 18;
            default: return 26;
        endcase
    endfunction

    // Folds one accepted point into the shadow extremes. On the last point of
    // a set it queues the k plane items: minima first, then maxima. In the
    // 18-plane mode the upper part of each half skips the diagonal group.
    task automatic fold_point(input t_coord x, input t_coord y, input t_coord z,
                              input logic last, input logic pin_en,
                              input logic [PLANE_IDX_W-1:0] pin_plane,
                              input t_dist pin_dist);
        t_dist      p [NUM_PROJ];
        t_dist      xs;
        t_dist      ys;
        t_dist      zs;
        int         k;
        int         half;
        int         j;
        int         s;
        t_plane_exp e;
        xs = t_dist'(x);
        ys = t_dist'(y);
        zs = t_dist'(z);
        p[0]  = xs;
        p[1]  = ys;
        p[2]  = zs;
        p[3]  = xs + ys + zs;
        p[4]  = xs - ys + zs;
        p[5]  = xs + ys - zs;
        p[6]  = xs - ys - zs;
        p[7]  = xs + ys;
        p[8]  = xs + zs;
        p[9]  = ys + zs;
        p[10] = xs - ys;
        p[11] = xs - zs;
        p[12] = ys - zs;
        for (int i = 0; i < NUM_PROJ; i++) begin
            if (!set_open) begin
                proj_lo[i] = p[i];
                proj_hi[i] = p[i];
            end else begin
                if (p[i] < proj_lo[i]) proj_lo[i] = p[i];
                if (p[i] > proj_hi[i]) proj_hi[i] = p[i];
            end
        end
        set_open = 1'b1;
        if (last) begin
            k = plane_total(mode_now);
            half = k / 2;
            for (int i = 0; i < k; i++) begin
                j = (i < half) ? i : i - half;
                s = (mode_now == DOP_18 && j >= 3) ? j + 4 : j;
                e.plane_index = PLANE_IDX_W'(i);
                e.plane_distance = (i < half) ? proj_lo[s] : proj_hi[s];
                if (pin_en && pin_plane == PLANE_IDX_W'(i)) begin
                    e.plane_distance = pin_dist;
                end
                e.last_plane = (i == k - 1);
                expected_planes = {expected_planes, e};
            end
            set_open = 1'b0;
        end
    endtask

    // Offers one point, idling first at random, and returns at the clock edge
    // that accepts it. Valid stays high so the next point can follow at once.
    task automatic send_point(input t_coord x, input t_coord y, input t_coord z,
                              input logic last, input logic pin_en,
                              input logic [PLANE_IDX_W-1:0] pin_plane,
                              input t_dist pin_dist);
        while ($urandom_range(99) < idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.point_x    <= x;
        pt_if.point_y    <= y;
        pt_if.point_z    <= z;
        pt_if.last_point <= last;
        do @(posedge i_clk); while (!pt_if.ready);
        fold_point(x, y, z, last, pin_en, pin_plane, pin_dist);
    endtask

    // Holds the point channel quiet until every queued plane item has come
    // back, then waits the given number of further cycles.
    task automatic wait_drained(input int settle);
        pt_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_planes.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // The mode register may only change while no plane item is pending.
    task automatic write_mode(input t_dop_mode mode);
        wait_drained(SETTLE_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_now     = mode;
    endtask

    // Coordinates lean on the two extremes and on small values near zero,
    // where the min/max comparisons flip most often.
    function automatic t_coord rand_coord();
        case ($urandom_range(9))
            0:       return CMAX;
            1:       return CMIN;
            2, 3:    return t_coord'($signed($urandom_range(2000)) - 1000);
            default: return t_coord'($urandom());
        endcase
    endfunction

    // Receiver: ready is held low in reset and otherwise redrawn every cycle
    // according to the stall odds.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pl_if.ready <= 1'b0;
        end else begin
            pl_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Every accepted plane item is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && pl_if.valid && pl_if.ready) begin
            if (expected_planes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected plane item: index %0d distance %0d last %0b",
                             $realtime, pl_if.plane_index, pl_if.plane_distance,
                             pl_if.last_plane);
                end
            end else begin
                head_plane = expected_planes.pop_front();
                if (pl_if.plane_index !== head_plane.plane_index ||
                    pl_if.plane_distance !== head_plane.plane_distance ||
                    pl_if.last_plane !== head_plane.last_plane) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: plane mismatch: index exp %0d got %0d,",
                                 $realtime, head_plane.plane_index, pl_if.plane_index,
                                 " distance exp %0d got %0d,",
                                 head_plane.plane_distance, pl_if.plane_distance,
                                 " last exp %0b got %0b",
                                 head_plane.last_plane, pl_if.last_plane);
                    end
                end
            end
        end
    end

    initial begin
        t_dir_row  row;
        int        sent;
        int        set_len;
        t_dop_mode phase_mode;

        mismatch_count = 0;
        set_open       = 1'b0;
        mode_now       = DOP_MODE_RESET;
        idle_pct       = 0;
        stall_pct      = 0;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        pt_if.valid      <= 1'b0;
        pt_if.point_x    <= '0;
        pt_if.point_y    <= '0;
        pt_if.point_z    <= '0;
        pt_if.last_point <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: walk the table, changing the mode where a row asks.
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.cfg_en) begin
                write_mode(row.cfg_mode);
            end
            send_point(row.x, row.y, row.z, row.last, row.pin_en, row.pin_plane,
                       row.pin_dist);
        end

        // Random part: well-formed point sets, mostly short, now and then up
        // to forty points. Each phase runs its own mode and idling pattern;
        // the last phase picks the mode at random.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       phase_mode = DOP_26;
                1:       phase_mode = DOP_6;
                2:       phase_mode = DOP_18;
                3:       phase_mode = DOP_14;
                default: phase_mode = t_dop_mode'($urandom_range(3));
            endcase
            write_mode(phase_mode);
            idle_pct  = SEND_IDLE[ph];
            stall_pct = RECV_STALL[ph];
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // Occasionally let the output side run completely dry.
                if ($urandom_range(39) == 0) begin
                    wait_drained(0);
                end
                set_len = ($urandom_range(9) == 0) ? $urandom_range(40, 1)
                                                   : $urandom_range(6, 1);
                for (int n = 1; n <= set_len; n++) begin
                    send_point(rand_coord(), rand_coord(), rand_coord(), n == set_len,
                               1'b0, '0, '0);
                end
                sent += set_len;
            end
        end

        // Collect the tail and give stray items a chance to show up.
        wait_drained(END_SETTLE);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
